@@ rtl/line_rasterizer_top_macros.svh @@
// Assertion macros shared by the line rasterizer modules.
`ifndef LINE_RASTERIZER_TOP_MACROS_SVH
`define LINE_RASTERIZER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define LR_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/lr_pkg.sv @@
`timescale 1ns / 1ps

package lr_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int ERR_EXTRA_BITS = 3;

    typedef enum logic
    {
        BK_IDLE,
        BK_DRAW
    } lr_back_state_t;

endpackage

@@ rtl/lr_seg_if.sv @@
`timescale 1ns / 1ps

interface lr_seg_if #(
    parameter int COORD_BITS = 6
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] first_x;
    logic [COORD_BITS-1:0] first_y;
    logic [COORD_BITS-1:0] second_x;
    logic [COORD_BITS-1:0] second_y;

    modport source (output valid, output first_x, output first_y,
                    output second_x, output second_y, input ready);
    modport sink (input valid, input first_x, input first_y,
                  input second_x, input second_y, output ready);
endinterface

@@ rtl/lr_pix_if.sv @@
`timescale 1ns / 1ps

interface lr_pix_if #(
    parameter int COORD_BITS = 6
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic                  last_pixel;

    modport source (output valid, output pixel_x, output pixel_y,
                    output last_pixel, input ready);
    modport sink (input valid, input pixel_x, input pixel_y,
                  input last_pixel, output ready);
endinterface

@@ rtl/line_rasterizer_top.sv @@
// A segment is registered in the front, the queue and the stepper before its first pixel shows.
// Throughput: one pixel per cycle while pix.ready is high; a segment gives major + 1 pixels
// (1 to 2^COORD_BITS), set by the single back-end stepping unit, with no gap between segments.
// A two-entry request queue and an input register let the front take new segments while drawing.
// Reset (rst_n, asynchronous, active low) empties the queue and idles the stepper.
`timescale 1ns / 1ps

module line_rasterizer_top
    import lr_pkg::*;
#(
    parameter int COORD_BITS = 6
)
(
    input  logic     clk,
    input  logic     rst_n,
    lr_seg_if.sink   seg,
    lr_pix_if.source pix
);

    localparam int CMD_W = 4 * COORD_BITS + 2;

    logic             fr_valid;
    logic             fr_ready;
    logic [CMD_W-1:0] fr_data;
    logic             bk_valid;
    logic             bk_ready;
    logic [CMD_W-1:0] bk_data;

    lr_front #(
        .COORD_BITS (COORD_BITS),
        .CMD_W      (CMD_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .seg       (seg),
        .cmd_valid (fr_valid),
        .cmd_ready (fr_ready),
        .cmd_data  (fr_data)
    );

    lr_queue #(
        .WIDTH (CMD_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fr_valid),
        .push_ready (fr_ready),
        .push_data  (fr_data),
        .pop_valid  (bk_valid),
        .pop_ready  (bk_ready),
        .pop_data   (bk_data)
    );

    lr_back #(
        .COORD_BITS (COORD_BITS),
        .CMD_W      (CMD_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (bk_valid),
        .cmd_ready (bk_ready),
        .cmd_data  (bk_data),
        .pix       (pix)
    );

endmodule

@@ rtl/lr_front.sv @@
`timescale 1ns / 1ps

module lr_front
    import lr_pkg::*;
#(
    parameter int COORD_BITS = 6,
    parameter int CMD_W = 4 * COORD_BITS + 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    lr_seg_if.sink           seg,
    output logic             cmd_valid,
    input  logic             cmd_ready,
    output logic [CMD_W-1:0] cmd_data
);

    typedef struct packed {
        logic                  shallow;
        logic                  neg;
        logic [COORD_BITS-1:0] a;
        logic [COORD_BITS-1:0] b;
        logic [COORD_BITS-1:0] major;
        logic [COORD_BITS-1:0] minor;
    } lr_cmd_t;

    logic                  valid_reg;
    logic                  valid_next;
    lr_cmd_t               cmd_reg;
    lr_cmd_t               cmd_next;
    logic                  accept;
    logic [COORD_BITS-1:0] adx;
    logic [COORD_BITS-1:0] ady;
    logic                  shallow;
    logic                  swap;
    logic [COORD_BITS-1:0] sx;
    logic [COORD_BITS-1:0] sy;
    logic [COORD_BITS-1:0] ex;
    logic [COORD_BITS-1:0] ey;
    logic [COORD_BITS-1:0] min_start;
    logic [COORD_BITS-1:0] min_end;

    assign seg.ready = !valid_reg || cmd_ready;
    assign accept    = seg.valid && seg.ready;
    assign cmd_valid = valid_reg;
    assign cmd_data  = cmd_reg;

    // The segment is reordered so that the major coordinate always counts up.
    always_comb
    begin
        adx = (seg.first_x > seg.second_x) ? (seg.first_x - seg.second_x)
                                           : (seg.second_x - seg.first_x);
        ady = (seg.first_y > seg.second_y) ? (seg.first_y - seg.second_y)
                                           : (seg.second_y - seg.first_y);
        shallow = ady < adx;
        swap    = shallow ? (seg.first_x > seg.second_x) : (seg.first_y > seg.second_y);
        sx = swap ? seg.second_x : seg.first_x;
        sy = swap ? seg.second_y : seg.first_y;
        ex = swap ? seg.first_x : seg.second_x;
        ey = swap ? seg.first_y : seg.second_y;
        min_start = shallow ? sy : sx;
        min_end   = shallow ? ey : ex;

        cmd_next.shallow = shallow;
        cmd_next.neg     = min_end < min_start;
        cmd_next.a       = shallow ? sx : sy;
        cmd_next.b       = min_start;
        cmd_next.major   = shallow ? (ex - sx) : (ey - sy);
        cmd_next.minor   = (min_end < min_start) ? (min_start - min_end)
                                                 : (min_end - min_start);
        valid_next = accept || (valid_reg && !cmd_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

@@ rtl/lr_queue.sv @@
`timescale 1ns / 1ps
`include "line_rasterizer_top_macros.svh"

module lr_queue
    import lr_pkg::*;
#(
    parameter int WIDTH = 26
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    logic [WIDTH-1:0] mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign push_ready = count_reg != FULL_CNT;
    assign pop_valid  = count_reg != '0;
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // The fill level never exceeds the storage, and pointers agree with it.
    `LR_ASSERT_IMP(a_q_count_bound, clk, rst_n, 1'b1, count_reg <= FULL_CNT, "queue overfilled")
    `LR_ASSERT_IMP(a_q_ptr_match, clk, rst_n, (count_reg == '0) || (count_reg == FULL_CNT), wr_ptr_reg == rd_ptr_reg, "queue pointers disagree with fill level")
    `LR_ASSERT_NXT(a_q_both, clk, rst_n, push && pop, $stable(count_reg), "fill level moved on push with pop")

endmodule

@@ rtl/lr_back.sv @@
`timescale 1ns / 1ps
`include "line_rasterizer_top_macros.svh"

module lr_back
    import lr_pkg::*;
#(
    parameter int COORD_BITS = 6,
    parameter int CMD_W = 4 * COORD_BITS + 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_ready,
    input  logic [CMD_W-1:0] cmd_data,
    lr_pix_if.source         pix
);

    localparam int EW = COORD_BITS + ERR_EXTRA_BITS;

    typedef struct packed {
        logic                  shallow;
        logic                  neg;
        logic [COORD_BITS-1:0] a;
        logic [COORD_BITS-1:0] b;
        logic [COORD_BITS-1:0] major;
        logic [COORD_BITS-1:0] minor;
    } lr_cmd_t;

    lr_back_state_t        state_reg;
    lr_back_state_t        state_next;
    lr_cmd_t               cmd_in;
    logic                  shallow_reg;
    logic                  shallow_next;
    logic                  neg_reg;
    logic                  neg_next;
    logic [COORD_BITS-1:0] a_reg;
    logic [COORD_BITS-1:0] a_next;
    logic [COORD_BITS-1:0] b_reg;
    logic [COORD_BITS-1:0] b_next;
    logic [COORD_BITS-1:0] cnt_reg;
    logic [COORD_BITS-1:0] cnt_next;
    logic [EW-1:0]         major2_reg;
    logic [EW-1:0]         major2_next;
    logic [EW-1:0]         minor2_reg;
    logic [EW-1:0]         minor2_next;
    logic signed [EW-1:0]  err_reg;
    logic signed [EW-1:0]  err_next;
    logic [EW-1:0]         in_major2;
    logic [EW-1:0]         in_minor2;
    logic                  fire;
    logic                  last;
    logic                  load;

    assign cmd_in         = cmd_data;
    assign last           = cnt_reg == '0;
    assign fire           = pix.valid && pix.ready;
    assign pix.valid      = state_reg == BK_DRAW;
    assign pix.pixel_x    = shallow_reg ? a_reg : b_reg;
    assign pix.pixel_y    = shallow_reg ? b_reg : a_reg;
    assign pix.last_pixel = last;
    assign in_major2      = {{(EW-COORD_BITS-1){1'b0}}, cmd_in.major, 1'b0};
    assign in_minor2      = {{(EW-COORD_BITS-1){1'b0}}, cmd_in.minor, 1'b0};
    assign load           = cmd_valid && cmd_ready;

    always_comb
    begin
        state_next   = state_reg;
        shallow_next = shallow_reg;
        neg_next     = neg_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        cnt_next     = cnt_reg;
        major2_next  = major2_reg;
        minor2_next  = minor2_reg;
        err_next     = err_reg;
        cmd_ready    = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                cmd_ready = 1'b1;
            end
            BK_DRAW:
            begin
                cmd_ready = fire && last;
                if (fire)
                begin
                    a_next   = a_reg + 1'b1;
                    cnt_next = cnt_reg - 1'b1;
                    if (err_reg > 0)
                    begin
                        b_next   = neg_reg ? (b_reg - 1'b1) : (b_reg + 1'b1);
                        err_next = err_reg - $signed(major2_reg) + $signed(minor2_reg);
                    end
                    else
                    begin
                        err_next = err_reg + $signed(minor2_reg);
                    end
                    if (last)
                    begin
                        state_next = BK_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
        if (load)
        begin
            state_next   = BK_DRAW;
            shallow_next = cmd_in.shallow;
            neg_next     = cmd_in.neg;
            a_next       = cmd_in.a;
            b_next       = cmd_in.b;
            cnt_next     = cmd_in.major;
            major2_next  = in_major2;
            minor2_next  = in_minor2;
            err_next     = $signed(in_minor2) - $signed({1'b0, in_major2[EW-1:1]});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shallow_reg <= shallow_next;
        neg_reg     <= neg_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        cnt_reg     <= cnt_next;
        major2_reg  <= major2_next;
        minor2_reg  <= minor2_next;
        err_reg     <= err_next;
    end

    // A taken pixel that is not the last one advances the major axis by one.
    `LR_ASSERT_NXT(a_bk_step, clk, rst_n, fire && !last, (state_reg == BK_DRAW) && (a_reg == $past(a_reg) + 1'b1) && (cnt_reg == $past(cnt_reg) - 1'b1), "major step lost")
    `LR_ASSERT_NXT(a_bk_end, clk, rst_n, fire && last && !cmd_valid, state_reg == BK_IDLE, "drawing continued past last pixel")
    `LR_ASSERT_IMP(a_bk_load, clk, rst_n, load, (state_reg == BK_IDLE) || (fire && last), "request loaded while a segment is in flight")

endmodule
